>>> design/stp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stp_pkg;

  localparam int SAMPLE_W    = 10;
  localparam int REG_W       = 12;
  localparam int NUM_SAMPLES = 8;
  localparam int NUM_PANELS  = 4;
  localparam int PANEL_W     = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int SPAN_W      = REG_W + 1;
  localparam int PROD_W      = SAMPLE_W + 1 + SPAN_W;
  localparam int MAG_W       = PROD_W - 1;
  localparam int EST_W       = REG_W + 1;
  localparam int SUM_W       = REG_W + 1;
  localparam int DIFF_W      = SUM_W + 1;

  localparam logic [SAMPLE_W-1:0] RAW_FULL = 10'd1023;

  localparam logic [REG_W-1:0] CALIB_LOW_RST  = 12'd0;
  localparam logic [REG_W-1:0] CALIB_HIGH_RST = 12'd1000;
  localparam logic [REG_W-1:0] STOP_DIFF_RST  = 12'd5;
  localparam logic [REG_W-1:0] START_DIFF_RST = 12'd30;
  localparam logic [REG_W-1:0] IDLE_PULSE_RST = 12'd1000;
  localparam logic [REG_W-1:0] RUN_PULSE_RST  = 12'd1500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CALIB_LOW,
    REG_CALIB_HIGH,
    REG_STOP_DIFF,
    REG_START_DIFF,
    REG_IDLE_PULSE,
    REG_RUN_PULSE
  } reg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0] calib_low;
    logic [REG_W-1:0] calib_high;
    logic [REG_W-1:0] stop_diff;
    logic [REG_W-1:0] start_diff;
    logic [REG_W-1:0] idle_pulse;
    logic [REG_W-1:0] run_pulse;
  } cfg_t;

  // one classified word handed from the front part to the motor logic
  typedef struct packed {
    logic [PANEL_W-1:0]       best;
    logic                     turn_r;
    logic signed [DIFF_W-1:0] diff;
  } qitem_t;

endpackage

`default_nettype wire

>>> design/stp_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface stp_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] sample_0;
  logic [9:0] sample_1;
  logic [9:0] sample_2;
  logic [9:0] sample_3;
  logic [9:0] sample_4;
  logic [9:0] sample_5;
  logic [9:0] sample_6;
  logic [9:0] sample_7;

  modport source (output valid, sample_0, sample_1, sample_2, sample_3,
                  sample_4, sample_5, sample_6, sample_7, input ready);
  modport sink (input valid, sample_0, sample_1, sample_2, sample_3,
                sample_4, sample_5, sample_6, sample_7, output ready);
endinterface

interface stp_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] left_pulse_us;
  logic [11:0] right_pulse_us;
  logic        left_running;
  logic        right_running;
  logic [1:0]  brightest_panel;
  logic        turn_right;

  modport source (output valid, left_pulse_us, right_pulse_us, left_running,
                  right_running, brightest_panel, turn_right, input ready);
  modport sink (input valid, left_pulse_us, right_pulse_us, left_running,
                right_running, brightest_panel, turn_right, output ready);
endinterface

interface stp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [11:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/sun_tracking_panel_selector.sv
// Throughput: one sample word per cycle while results.ready stays high; six front stages
// (multiply, divide by 1023 in two steps, panel sums, argmax, neighbour compare) feed a
// two-word queue and the motor stage.
// Reset (synchronous, rst high) empties the pipeline and queue, loads register defaults,
// clears both running flags and sets both pulses to the default idle pulse of 1000.
`timescale 1ns / 1ps
`default_nettype none

module sun_tracking_panel_selector (
  input  logic      clk,
  input  logic      rst,
  stp_in_if.sink    samples,
  stp_out_if.source results,
  stp_cfg_if.sink   cfg
);

  stp_pkg::cfg_t   regs;
  logic            push_valid, push_ready;
  stp_pkg::qitem_t push_item;
  logic            pop_valid, pop_ready;
  stp_pkg::qitem_t pop_item;

  stp_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  stp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .regs       (regs),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  stp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  stp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .results   (results)
  );

endmodule

`default_nettype wire

>>> design/stp_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module stp_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  stp_cfg_if.sink       cfg,
  output stp_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.calib_low  <= stp_pkg::CALIB_LOW_RST;
      regs.calib_high <= stp_pkg::CALIB_HIGH_RST;
      regs.stop_diff  <= stp_pkg::STOP_DIFF_RST;
      regs.start_diff <= stp_pkg::START_DIFF_RST;
      regs.idle_pulse <= stp_pkg::IDLE_PULSE_RST;
      regs.run_pulse  <= stp_pkg::RUN_PULSE_RST;
    end else if (cfg.valid) begin
      case (stp_pkg::reg_idx_t'(cfg.index))
        stp_pkg::REG_CALIB_LOW:  regs.calib_low  <= cfg.data;
        stp_pkg::REG_CALIB_HIGH: regs.calib_high <= cfg.data;
        stp_pkg::REG_STOP_DIFF:  regs.stop_diff  <= cfg.data;
        stp_pkg::REG_START_DIFF: regs.start_diff <= cfg.data;
        stp_pkg::REG_IDLE_PULSE: regs.idle_pulse <= cfg.data;
        stp_pkg::REG_RUN_PULSE:  regs.run_pulse  <= cfg.data;
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/stp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module stp_front (
  input  logic            clk,
  input  logic            rst,
  stp_in_if.sink          samples,
  input  stp_pkg::cfg_t   regs,
  output logic            push_valid,
  input  logic            push_ready,
  output stp_pkg::qitem_t push_item
);

  localparam int NS = stp_pkg::NUM_SAMPLES;
  localparam int NP = stp_pkg::NUM_PANELS;

  logic [stp_pkg::SAMPLE_W-1:0] raw [NS];

  assign raw[0] = samples.sample_0;
  assign raw[1] = samples.sample_1;
  assign raw[2] = samples.sample_2;
  assign raw[3] = samples.sample_3;
  assign raw[4] = samples.sample_4;
  assign raw[5] = samples.sample_5;
  assign raw[6] = samples.sample_6;
  assign raw[7] = samples.sample_7;

  // stage valids and enables; a stage loads when it is empty or the next one loads
  logic v_a, v_b, v_c, v_d, v_e, v_f;
  logic en_a, en_b, en_c, en_d, en_e, en_f;

  assign en_f = !v_f || push_ready;
  assign en_e = !v_e || en_f;
  assign en_d = !v_d || en_e;
  assign en_c = !v_c || en_d;
  assign en_b = !v_b || en_c;
  assign en_a = !v_a || en_b;

  assign samples.ready = en_a;
  assign push_valid    = v_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
      v_e <= 1'b0;
      v_f <= 1'b0;
    end else begin
      if (en_a) v_a <= samples.valid;
      if (en_b) v_b <= v_a;
      if (en_c) v_c <= v_b;
      if (en_d) v_d <= v_c;
      if (en_e) v_e <= v_d;
      if (en_f) v_f <= v_e;
    end
  end

  // stage A: x * (high - low), one multiplier per sample lane
  logic signed [stp_pkg::SPAN_W-1:0] span;
  logic signed [stp_pkg::PROD_W-1:0] prod_a [NS];

  assign span = $signed({1'b0, regs.calib_high}) - $signed({1'b0, regs.calib_low});

  // stage B: magnitude and a low estimate of magnitude / 1023
  logic [stp_pkg::MAG_W-1:0] mag_b [NS];
  logic [stp_pkg::EST_W-1:0] est_b [NS];
  logic                      neg_b [NS];

  // stage C: corrected quotient
  logic [stp_pkg::REG_W-1:0] q_c   [NS];
  logic                      neg_c [NS];

  // stage D: panel sums
  logic [stp_pkg::SUM_W-1:0] sum_d [NP];

  for (genvar i = 0; i < NS; i++) begin : g_lane
    logic signed [stp_pkg::PROD_W-1:0] prod_n;
    logic signed [stp_pkg::PROD_W-1:0] prod_neg;
    logic [stp_pkg::MAG_W-1:0]         mag_n;
    logic [stp_pkg::PROD_W-1:0]        est_sum;
    logic [stp_pkg::MAG_W-1:0]         est_x_full;
    logic [stp_pkg::MAG_W-1:0]         rem;
    logic [stp_pkg::EST_W-1:0]         q_n;

    assign prod_n   = $signed({1'b0, raw[i]}) * span;
    assign prod_neg = -prod_a[i];
    assign mag_n    = prod_a[i][stp_pkg::PROD_W-1] ? prod_neg[stp_pkg::MAG_W-1:0]
                                                   : prod_a[i][stp_pkg::MAG_W-1:0];
    // m/1023 = m/1024 * (1 + 2^-10 + 2^-20 + ...); never high, at most one low
    assign est_sum  = {1'b0, mag_n} + stp_pkg::PROD_W'(mag_n >> 10)
                    + stp_pkg::PROD_W'(mag_n >> 20);

    assign est_x_full = {est_b[i], 10'b0} - {10'b0, est_b[i]};
    assign rem        = mag_b[i] - est_x_full;
    assign q_n        = (rem >= stp_pkg::MAG_W'(stp_pkg::RAW_FULL)) ? est_b[i] + 1'b1
                                                                    : est_b[i];

    always_ff @(posedge clk) begin
      if (en_a) prod_a[i] <= prod_n;
      if (en_b) begin
        mag_b[i] <= mag_n;
        est_b[i] <= est_sum[stp_pkg::MAG_W-1:10];
        neg_b[i] <= prod_a[i][stp_pkg::PROD_W-1];
      end
      if (en_c) begin
        q_c[i]   <= q_n[stp_pkg::REG_W-1:0];
        neg_c[i] <= neg_b[i];
      end
    end
  end

  logic [stp_pkg::REG_W-1:0] scaled [NS];

  for (genvar i = 0; i < NS; i++) begin : g_scale
    logic [stp_pkg::REG_W:0] s_full;
    // result always lies between low and high, so 12 bits hold it
    assign s_full    = neg_c[i] ? {1'b0, regs.calib_low} - {1'b0, q_c[i]}
                                : {1'b0, regs.calib_low} + {1'b0, q_c[i]};
    assign scaled[i] = s_full[stp_pkg::REG_W-1:0];
  end

  for (genvar k = 0; k < NP; k++) begin : g_panel
    always_ff @(posedge clk) begin
      if (en_d) sum_d[k] <= {1'b0, scaled[2*k]} + {1'b0, scaled[2*k+1]};
    end
  end

  // stage E: brightest panel on halved sums, later panel wins a tie
  logic [stp_pkg::SUM_W-1:0]   sum_e [NP];
  logic [stp_pkg::PANEL_W-1:0] best_e;
  logic [stp_pkg::PANEL_W-1:0] best_n;

  always_comb begin
    logic [stp_pkg::SUM_W-2:0] bestv;
    best_n = '0;
    bestv  = sum_d[0][stp_pkg::SUM_W-1:1];
    for (int k = 1; k < NP; k++) begin
      if (sum_d[k][stp_pkg::SUM_W-1:1] >= bestv) begin
        best_n = stp_pkg::PANEL_W'(k);
        bestv  = sum_d[k][stp_pkg::SUM_W-1:1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_e) begin
      for (int k = 0; k < NP; k++) sum_e[k] <= sum_d[k];
      best_e <= best_n;
    end
  end

  // stage F: ring neighbours, turn direction and difference
  logic [stp_pkg::SUM_W-1:0] s_best, s_left, s_right;
  stp_pkg::qitem_t           item_n;

  always_comb begin
    case (best_e)
      2'd0: begin s_best = sum_e[0]; s_left = sum_e[3]; s_right = sum_e[1]; end
      2'd1: begin s_best = sum_e[1]; s_left = sum_e[0]; s_right = sum_e[2]; end
      2'd2: begin s_best = sum_e[2]; s_left = sum_e[1]; s_right = sum_e[3]; end
      default: begin s_best = sum_e[3]; s_left = sum_e[2]; s_right = sum_e[0]; end
    endcase
    item_n.best   = best_e;
    item_n.turn_r = (s_right >= s_left);
    item_n.diff   = $signed({1'b0, s_best})
                  - $signed({1'b0, item_n.turn_r ? s_right : s_left});
  end

  always_ff @(posedge clk) begin
    if (en_f) push_item <= item_n;
  end

endmodule

`default_nettype wire

>>> design/stp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module stp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  stp_pkg::qitem_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output stp_pkg::qitem_t pop_item
);

  stp_pkg::qitem_t entry [2];
  logic            wr_ptr, rd_ptr;
  logic [1:0]      count;
  logic            do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= push_item;
  end

endmodule

`default_nettype wire

>>> design/stp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module stp_back (
  input  logic            clk,
  input  logic            rst,
  input  stp_pkg::cfg_t   regs,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  stp_pkg::qitem_t pop_item,
  stp_out_if.source       results
);

  logic                      left_on, right_on;
  logic                      left_on_next, right_on_next;
  logic [stp_pkg::REG_W-1:0] left_pulse, right_pulse;
  logic [stp_pkg::REG_W-1:0] left_pulse_next, right_pulse_next;
  logic [stp_pkg::PANEL_W-1:0] best;
  logic                      turn_r;
  logic                      out_valid;
  logic                      fire;

  logic signed [stp_pkg::DIFF_W-1:0] stop2, start2;

  assign pop_ready = !out_valid || results.ready;
  assign fire      = pop_valid && pop_ready;
  assign stop2     = $signed({1'b0, regs.stop_diff, 1'b0});
  assign start2    = $signed({1'b0, regs.start_diff, 1'b0});

  always_comb begin
    left_on_next     = left_on;
    right_on_next    = right_on;
    left_pulse_next  = left_pulse;
    right_pulse_next = right_pulse;
    // idle the opposite motor, its running flag stays set
    if (pop_item.turn_r && left_on)   left_pulse_next  = regs.idle_pulse;
    if (!pop_item.turn_r && right_on) right_pulse_next = regs.idle_pulse;
    if (pop_item.turn_r) begin
      if (right_on) begin
        if (pop_item.diff < stop2) begin
          right_pulse_next = regs.idle_pulse;
          right_on_next    = 1'b0;
        end
      end else if (pop_item.diff > start2) begin
        right_pulse_next = regs.run_pulse;
        right_on_next    = 1'b1;
      end
    end else begin
      if (left_on) begin
        if (pop_item.diff < stop2) begin
          left_pulse_next = regs.idle_pulse;
          left_on_next    = 1'b0;
        end
      end else if (pop_item.diff > start2) begin
        left_pulse_next = regs.run_pulse;
        left_on_next    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_on     <= 1'b0;
      right_on    <= 1'b0;
      left_pulse  <= stp_pkg::IDLE_PULSE_RST;
      right_pulse <= stp_pkg::IDLE_PULSE_RST;
      out_valid   <= 1'b0;
    end else begin
      if (fire) begin
        left_on     <= left_on_next;
        right_on    <= right_on_next;
        left_pulse  <= left_pulse_next;
        right_pulse <= right_pulse_next;
      end
      if (pop_ready) out_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      best   <= pop_item.best;
      turn_r <= pop_item.turn_r;
    end
  end

  // motor state only moves when a new word loads, so it doubles as the output word
  assign results.valid           = out_valid;
  assign results.left_pulse_us   = left_pulse;
  assign results.right_pulse_us  = right_pulse;
  assign results.left_running    = left_on;
  assign results.right_running   = right_on;
  assign results.brightest_panel = best;
  assign results.turn_right      = turn_r;

endmodule

`default_nettype wire

>>> design/stp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module stp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] left_pulse_us,
  input logic [11:0] right_pulse_us,
  input logic        left_running,
  input logic [1:0]  brightest_panel,
  input logic        turn_right,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // after reset the pipeline is empty and takes a word at once
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("result valid or input stalled right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_pulse_us)
      && $stable(right_pulse_us) && $stable(brightest_panel) && $stable(turn_right))
    else $error("stalled result word changed");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

  // a right turn never starts the left motor
  a_no_left_start: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !left_running) ##1 (out_valid && turn_right)
      |-> !left_running)
    else $error("left motor started on a right turn");

endmodule

bind sun_tracking_panel_selector stp_checker u_stp_checker (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (samples.ready),
  .out_valid       (results.valid),
  .out_ready       (results.ready),
  .left_pulse_us   (results.left_pulse_us),
  .right_pulse_us  (results.right_pulse_us),
  .left_running    (results.left_running),
  .brightest_panel (results.brightest_panel),
  .turn_right      (results.turn_right),
  .cfg_valid       (cfg.valid),
  .cfg_ready       (cfg.ready)
);

`default_nettype wire

>>> test/sun_tracking_panel_selector_tb.sv
`timescale 1ns / 1ps

module sun_tracking_panel_selector_tb;

  typedef logic [stp_pkg::NUM_SAMPLES-1:0][stp_pkg::SAMPLE_W-1:0] samples_t;

  typedef struct packed {
    logic [stp_pkg::REG_W-1:0]   left_us;
    logic [stp_pkg::REG_W-1:0]   right_us;
    logic                        left_on;
    logic                        right_on;
    logic [stp_pkg::PANEL_W-1:0] panel;
    logic                        turn_r;
  } motor_cmd_t;

  // indexes past the last register; the block must drop these writes
  localparam logic [stp_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [stp_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam int SEG_ITEMS    = 315;
  localparam int NUM_SEGS     = 6;
  localparam int STALL_CYCLES = 300;
  localparam int MAX_PRINTS   = 100;

  class motor_cmd_board;
    logic [stp_pkg::REG_W-1:0] cal_lo, cal_hi, stop_th, start_th, idle_us, run_us;
    logic                      left_on, right_on;
    logic [stp_pkg::REG_W-1:0] left_us, right_us;
    motor_cmd_t                expected_cmds[$];
    int                        n_errors;

    function new();
      cal_lo   = stp_pkg::CALIB_LOW_RST;
      cal_hi   = stp_pkg::CALIB_HIGH_RST;
      stop_th  = stp_pkg::STOP_DIFF_RST;
      start_th = stp_pkg::START_DIFF_RST;
      idle_us  = stp_pkg::IDLE_PULSE_RST;
      run_us   = stp_pkg::RUN_PULSE_RST;
      left_on  = 1'b0;
      right_on = 1'b0;
      left_us  = stp_pkg::IDLE_PULSE_RST;
      right_us = stp_pkg::IDLE_PULSE_RST;
      n_errors = 0;
    endfunction

    task report_mismatch(string msg);
      // keep the log short when the block is badly off
      if (n_errors < MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
      n_errors++;
    endtask

    function int scaled(logic [stp_pkg::SAMPLE_W-1:0] raw);
      int lo, span;
      lo   = int'(cal_lo);
      span = int'(cal_hi) - lo;
      // signed division truncates toward zero, so a reversed range works too
      return lo + (int'(raw) * span) / int'(stp_pkg::RAW_FULL);
    endfunction

    function void write_reg(logic [stp_pkg::CFG_IDX_W-1:0] idx,
                            logic [stp_pkg::REG_W-1:0] v);
      case (idx)
        stp_pkg::REG_CALIB_LOW:  cal_lo   = v;
        stp_pkg::REG_CALIB_HIGH: cal_hi   = v;
        stp_pkg::REG_STOP_DIFF:  stop_th  = v;
        stp_pkg::REG_START_DIFF: start_th = v;
        stp_pkg::REG_IDLE_PULSE: idle_us  = v;
        stp_pkg::REG_RUN_PULSE:  run_us   = v;
        default: ;
      endcase
    endfunction

    function void take_samples(samples_t w);
      int         sum [stp_pkg::NUM_PANELS];
      int         best, best_half, li, ri, d;
      logic       tr;
      motor_cmd_t c;
      for (int k = 0; k < stp_pkg::NUM_PANELS; k++)
        sum[k] = scaled(w[2*k]) + scaled(w[2*k+1]);
      best      = 0;
      best_half = sum[0] / 2;
      // ties go to the later panel
      for (int k = 1; k < stp_pkg::NUM_PANELS; k++) begin
        if (sum[k] / 2 >= best_half) begin
          best      = k;
          best_half = sum[k] / 2;
        end
      end
      li = (best + 3) % stp_pkg::NUM_PANELS;
      ri = (best + 1) % stp_pkg::NUM_PANELS;
      tr = (sum[ri] >= sum[li]);
      // idle the opposite motor but leave its running flag alone
      if (tr && left_on) left_us = idle_us;
      if (!tr && right_on) right_us = idle_us;
      if (tr) begin
        d = sum[best] - sum[ri];
        if (right_on) begin
          if (d < 2 * int'(stop_th)) begin
            right_us = idle_us;
            right_on = 1'b0;
          end
        end else if (d > 2 * int'(start_th)) begin
          right_us = run_us;
          right_on = 1'b1;
        end
      end else begin
        d = sum[best] - sum[li];
        if (left_on) begin
          if (d < 2 * int'(stop_th)) begin
            left_us = idle_us;
            left_on = 1'b0;
          end
        end else if (d > 2 * int'(start_th)) begin
          left_us = run_us;
          left_on = 1'b1;
        end
      end
      c.left_us  = left_us;
      c.right_us = right_us;
      c.left_on  = left_on;
      c.right_on = right_on;
      c.panel    = stp_pkg::PANEL_W'(best);
      c.turn_r   = tr;
      expected_cmds.push_back(c);
    endfunction

    task cmp(string name, logic [stp_pkg::REG_W-1:0] got_v,
             logic [stp_pkg::REG_W-1:0] want_v);
      if (got_v !== want_v)
        report_mismatch($sformatf("%s got %0d expected %0d", name, got_v, want_v));
    endtask

    task check_cmd(motor_cmd_t got);
      motor_cmd_t want;
      if (expected_cmds.size() == 0) begin
        report_mismatch("result word with none expected");
        return;
      end
      want = expected_cmds.pop_front();
      cmp("left_pulse_us", got.left_us, want.left_us);
      cmp("right_pulse_us", got.right_us, want.right_us);
      cmp("left_running", got.left_on, want.left_on);
      cmp("right_running", got.right_on, want.right_on);
      cmp("brightest_panel", got.panel, want.panel);
      cmp("turn_right", got.turn_r, want.turn_r);
    endtask

    task flush_leftover();
      if (expected_cmds.size() != 0)
        report_mismatch($sformatf("%0d result words never arrived", expected_cmds.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  stp_in_if  in_if();
  stp_out_if out_if();
  stp_cfg_if cfg_if();

  motor_cmd_board board;
  int             src_idle_pct;
  int             snk_idle_pct;
  int             hold_left;
  bit             stall_req;

  sun_tracking_panel_selector u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (in_if),
    .results (out_if),
    .cfg     (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // sample every handshake at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) board.write_reg(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready)
        board.take_samples({in_if.sample_7, in_if.sample_6, in_if.sample_5, in_if.sample_4,
                            in_if.sample_3, in_if.sample_2, in_if.sample_1, in_if.sample_0});
      if (out_if.valid && out_if.ready)
        board.check_cmd(motor_cmd_t'({out_if.left_pulse_us, out_if.right_pulse_us,
                                      out_if.left_running, out_if.right_running,
                                      out_if.brightest_panel, out_if.turn_right}));
    end
  end

  // receiver: random ready, or a long hold-off when asked
  initial begin
    out_if.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        hold_left = STALL_CYCLES;
        stall_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  function automatic samples_t mk_word(int a0, int a1, int a2, int a3,
                                       int a4, int a5, int a6, int a7);
    return {10'(a7), 10'(a6), 10'(a5), 10'(a4), 10'(a3), 10'(a2), 10'(a1), 10'(a0)};
  endfunction

  function automatic samples_t rand_word();
    samples_t w;
    int       mode, sun, nb, base, bump, lvl, flat;
    mode = $urandom_range(99);
    if (mode < 15) begin
      for (int k = 0; k < stp_pkg::NUM_SAMPLES; k++) w[k] = 10'($urandom_range(1023));
    end else if (mode < 25) begin
      for (int k = 0; k < stp_pkg::NUM_SAMPLES; k++)
        w[k] = $urandom_range(1) ? 10'd1023 : 10'd0;
    end else if (mode < 35) begin
      // nearly flat light: ties and tiny differences
      flat = $urandom_range(1023);
      for (int k = 0; k < stp_pkg::NUM_SAMPLES; k++)
        w[k] = 10'(flat) ^ 10'($urandom_range(1));
    end else begin
      // sun over one panel, partly spilling onto a neighbour
      sun  = $urandom_range(3);
      nb   = (sun + ($urandom_range(1) ? 1 : 3)) % stp_pkg::NUM_PANELS;
      base = $urandom_range(0, 700);
      bump = ($urandom_range(3) == 0) ? $urandom_range(0, 320) : $urandom_range(0, 24);
      for (int k = 0; k < stp_pkg::NUM_SAMPLES; k++) begin
        lvl = base + $urandom_range(0, 3);
        if (k / 2 == sun) lvl += bump;
        else if (k / 2 == nb) lvl += bump * $urandom_range(0, 3) / 4;
        w[k] = (lvl > 1023) ? 10'd1023 : 10'(lvl);
      end
    end
    return w;
  endfunction

  // leaves valid high so back-to-back words need no toggle
  task send_word(input samples_t w);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    {in_if.sample_7, in_if.sample_6, in_if.sample_5, in_if.sample_4,
     in_if.sample_3, in_if.sample_2, in_if.sample_1, in_if.sample_0} = w;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task stop_sending();
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  task wait_drained();
    while (board.expected_cmds.size() != 0) @(posedge clk);
    repeat (10) @(negedge clk);
  endtask

  task put_reg(input logic [stp_pkg::CFG_IDX_W-1:0] idx,
               input logic [stp_pkg::REG_W-1:0] v);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = v;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task program_regs(input logic [stp_pkg::REG_W-1:0] lo, hi, stop, start, idle, run);
    put_reg(stp_pkg::REG_CALIB_LOW, lo);
    put_reg(stp_pkg::REG_CALIB_HIGH, hi);
    put_reg(stp_pkg::REG_STOP_DIFF, stop);
    put_reg(stp_pkg::REG_START_DIFF, start);
    put_reg(stp_pkg::REG_IDLE_PULSE, idle);
    put_reg(stp_pkg::REG_RUN_PULSE, run);
    put_reg(REG_SPARE_6, 12'($urandom));
    put_reg(REG_SPARE_7, 12'($urandom));
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task load_setting(input int seg);
    case (seg)
      0: program_regs(12'd0, 12'd4095, 12'($urandom_range(0, 40)), 12'($urandom_range(0, 120)),
                      12'($urandom), 12'($urandom));
      1: program_regs(12'd4095, 12'd0, 12'd0, 12'd0, 12'd0, 12'd4095);
      2: program_regs(12'($urandom), 12'($urandom), 12'($urandom_range(0, 200)),
                      12'($urandom_range(0, 400)), 12'($urandom), 12'($urandom));
      // start on any lead, stop on the next word: motors toggle
      3: program_regs(12'($urandom_range(0, 2000)), 12'd4095, 12'd4095, 12'd0,
                      12'($urandom), 12'($urandom));
      4: program_regs(12'd0, 12'd1023, 12'($urandom_range(0, 30)), 12'($urandom_range(0, 60)),
                      12'($urandom), 12'($urandom));
      default: program_regs(12'd4095, 12'($urandom), 12'($urandom_range(0, 100)), 12'd4095,
                            12'd4095, 12'd0);
    endcase
  endtask

  initial begin
    board         = new();
    rst           = 1'b1;
    stall_req     = 1'b0;
    src_idle_pct  = 25;
    snk_idle_pct  = 47;
    in_if.valid   = 1'b0;
    {in_if.sample_7, in_if.sample_6, in_if.sample_5, in_if.sample_4,
     in_if.sample_3, in_if.sample_2, in_if.sample_1, in_if.sample_0} = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: extremes, each panel lit alone, flat light, bit patterns
    send_word(mk_word(0, 0, 0, 0, 0, 0, 0, 0));
    send_word(mk_word(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023));
    for (int p = 0; p < stp_pkg::NUM_PANELS; p++) begin
      send_word(mk_word(p == 0 ? 1023 : 0, p == 0 ? 1023 : 0, p == 1 ? 1023 : 0,
                        p == 1 ? 1023 : 0, p == 2 ? 1023 : 0, p == 2 ? 1023 : 0,
                        p == 3 ? 1023 : 0, p == 3 ? 1023 : 0));
    end
    send_word(mk_word(512, 512, 512, 512, 512, 512, 512, 512));
    send_word(mk_word('h2AA, 'h155, 'h2AA, 'h155, 'h2AA, 'h155, 'h2AA, 'h155));
    stop_sending();
    wait_drained();

    // identity scale so panel sums are exact
    program_regs(12'd0, 12'd1023, 12'd5, 12'd30, 12'd1000, 12'd1500);
    send_word(mk_word(100, 100, 500, 500, 0, 0, 0, 0));   // left starts
    send_word(mk_word(0, 0, 500, 500, 100, 100, 0, 0));   // right starts, left idled but set
    send_word(mk_word(495, 495, 500, 500, 0, 0, 0, 0));   // right idled, left holds at limit
    send_word(mk_word(497, 498, 500, 500, 0, 0, 0, 0));   // left stops
    send_word(mk_word(0, 0, 0, 0, 50, 51, 50, 50));       // brightest below neighbour
    send_word(mk_word(0, 0, 0, 0, 200, 200, 1023, 1023));
    send_word(mk_word(0, 0, 0, 0, 50, 51, 50, 50));       // negative lead stops left
    send_word(mk_word(100, 100, 0, 0, 0, 0, 100, 101));   // halved tie, later panel
    stop_sending();
    wait_drained();

    // reversed calibration
    program_regs(12'd4095, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd0);
    send_word(mk_word(0, 0, 0, 0, 0, 0, 0, 0));
    send_word(mk_word(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023));
    send_word(mk_word(1, 1, 512, 512, 1022, 1022, 0, 1023));
    send_word(mk_word(1023, 0, 700, 3, 0, 0, 1, 2));
    stop_sending();
    wait_drained();

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg / 2)
        0: begin
          src_idle_pct = 25;
          snk_idle_pct = 47;
        end
        1: begin
          src_idle_pct = 47;
          snk_idle_pct = 25;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      load_setting(seg);
      for (int i = 0; i < SEG_ITEMS; i++) begin
        // back up the pipeline while words keep coming
        if ((seg == 1 || seg == 4) && i == 100) stall_req = 1'b1;
        send_word(rand_word());
      end
      stop_sending();
      wait_drained();
    end

    for (int i = 0; i < 20000 && board.expected_cmds.size() != 0; i++) @(posedge clk);
    repeat (20) @(posedge clk);
    board.flush_leftover();
    if (board.n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sun_tracking_panel_selector.f
design/stp_pkg.sv
design/stp_ifs.sv
design/stp_cfg_regs.sv
design/stp_front.sv
design/stp_queue.sv
design/stp_back.sv
design/sun_tracking_panel_selector.sv
design/stp_checker.sv
test/sun_tracking_panel_selector_tb.sv
